FILE: src/daisy_chain_pec_checker_top_defines.svh
// -----------------------------------------------------------------------------
// Daisy-chain PEC checker assertion macros
// Assertion wrappers shared by the checker RTL; empty when SYNTHESIS is set.
// -----------------------------------------------------------------------------
`ifndef DAISY_CHAIN_PEC_CHECKER_TOP_DEFINES_SVH
`define DAISY_CHAIN_PEC_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define DCPC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcpc assertion failed");
// Next-cycle implication, disabled during reset
`define DCPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcpc assertion failed");
`else
`define DCPC_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define DCPC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: src/dcpc_pkg.sv
// -----------------------------------------------------------------------------
// Daisy-chain PEC checker package
// Shared widths, CRC constants and register indexes.
// -----------------------------------------------------------------------------
package dcpc_pkg;

   // CRC-8, polynomial x^8 + x^2 + x + 1, no reflection, no final xor
   localparam logic [7:0] CrcStart = 8'h41;
   localparam logic [7:0] CrcPoly  = 8'h07;

   // Device chain limits
   localparam int MaxDevices = 16;
   localparam int MaskWidth  = 16;

   // Stream payload widths
   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 40;

   // Configuration port
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 6;
   localparam logic [CsrIndexWidth-1:0] RegDeviceCount    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] RegBytesPerDevice = 2'd1;

   // Register reset values
   localparam logic [4:0] DeviceCountReset    = 5'd1;
   localparam logic [5:0] BytesPerDeviceReset = 6'd18;

   typedef logic [7:0] crc_type;

endpackage

FILE: src/dcpc_crc8.sv
// -----------------------------------------------------------------------------
// Daisy-chain PEC checker CRC-8 byte update
// Advances a CRC-8 register by one data byte, MSB first.
// -----------------------------------------------------------------------------
module dcpc_crc8 (
   input  dcpc_pkg::crc_type crc_in,
   input  logic [7:0]        data_in,
   output dcpc_pkg::crc_type crc_out
);
   import dcpc_pkg::*;

   // Eight shift steps of the bitwise CRC, one per data bit
   always_comb begin
      crc_type c;
      c = crc_in ^ data_in;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      crc_out = c;
   end

endmodule

FILE: src/daisy_chain_pec_checker_top.sv
// -----------------------------------------------------------------------------
// Daisy-chain PEC checker
// Tracks segment and device position in a daisy-chained response, runs a
// CRC-8 over each segment's data bytes and reports every check byte.
//
// Channel   Dir  Transfer per            Payload
// req_      in   received byte           tdata = rx_byte, tuser = frame_start
// rsp_      out  check byte              tdata = device/PEC/mask, tlast = last
// csr_      in   register write          index, data
//
// One byte is taken per cycle. A check byte's result appears in the output
// register on the cycle after its transfer; data bytes give no result.
// The CRC byte update plus position compare form one combinational path.
// A held output only stalls req_ while a result is waiting and not taken.
// Sync active-high reset clears positions and mask, presets CRC and registers.
// -----------------------------------------------------------------------------
`include "daisy_chain_pec_checker_top_defines.svh"

module daisy_chain_pec_checker_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // Byte input
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [dcpc_pkg::ReqDataWidth-1:0]      req_tdata,  // [7:0] rx_byte
   input  logic                                   req_tuser,  // [0] frame_start
   // Check result output
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [3:0] device_index, [4] pec_ok, [12:5] received_pec,
   // [20:13] computed_pec, [36:21] mismatch_mask, [39:37] zero
   output logic [dcpc_pkg::RspDataWidth-1:0]      rsp_tdata,
   output logic                                   rsp_tlast,  // last_device
   // Register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dcpc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [dcpc_pkg::CsrDataWidth-1:0]      csr_data
);
   import dcpc_pkg::*;

   // Registers
   logic [4:0]           dev_count_ff;
   logic [5:0]           bytes_per_dev_ff;
   crc_type              crc_ff, crc_in;
   logic [5:0]           byte_pos_ff, byte_pos_in;
   logic [3:0]           dev_pos_ff, dev_pos_in;
   logic [MaskWidth-1:0] mask_ff, mask_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RspDataWidth-1:0] rsp_data_ff;
   logic                 rsp_last_ff;

   // Working values
   logic                 req_xfer;
   logic                 csr_xfer;
   logic                 rx_start;
   logic [7:0]           rx_byte;
   crc_type              crc_base, crc_next;
   logic [5:0]           byte_pos_base;
   logic [3:0]           dev_pos_base;
   logic [MaskWidth-1:0] mask_base, mask_new, dev_bit;
   logic                 is_data;
   logic                 pec_ok;
   logic                 last_dev;
   logic [4:0]           eff_devices;

   assign req_xfer  = req_tvalid & req_tready;
   assign csr_xfer  = csr_valid & csr_ready;
   assign csr_ready = 1'b1;
   assign rx_byte   = req_tdata[7:0];
   assign rx_start  = req_tuser;

   // Frame start restarts the state before the byte is handled
   assign crc_base      = rx_start ? CrcStart : crc_ff;
   assign byte_pos_base = rx_start ? 6'd0 : byte_pos_ff;
   assign dev_pos_base  = rx_start ? 4'd0 : dev_pos_ff;
   assign mask_base     = rx_start ? '0 : mask_ff;

   dcpc_crc8 u_crc8 (
      .crc_in  (crc_base),
      .data_in (rx_byte),
      .crc_out (crc_next)
   );

   // Devices per frame: zero counts as one, clamped to the chain limit
   always_comb begin
      if (dev_count_ff == 5'd0) begin
         eff_devices = 5'd1;
      end else if (32'(dev_count_ff) > MaxDevices) begin
         eff_devices = 5'(MaxDevices);
      end else begin
         eff_devices = dev_count_ff;
      end
   end

   // Byte classification and check result
   assign is_data  = byte_pos_base < bytes_per_dev_ff;
   assign pec_ok   = rx_byte == crc_base;
   assign dev_bit  = MaskWidth'(1) << dev_pos_base;
   assign mask_new = pec_ok ? mask_base : (mask_base | dev_bit);
   assign last_dev = ({1'b0, dev_pos_base} + 5'd1) >= eff_devices;

   // Next segment state
   always_comb begin
      crc_in      = crc_ff;
      byte_pos_in = byte_pos_ff;
      dev_pos_in  = dev_pos_ff;
      mask_in     = mask_ff;
      if (req_xfer) begin
         if (is_data) begin
            crc_in      = crc_next;
            byte_pos_in = byte_pos_base + 6'd1;
            dev_pos_in  = dev_pos_base;
            mask_in     = mask_base;
         end else begin
            crc_in      = CrcStart;
            byte_pos_in = 6'd0;
            dev_pos_in  = last_dev ? 4'd0 : (dev_pos_base + 4'd1);
            mask_in     = last_dev ? '0 : mask_new;
         end
      end
   end

   // Output register: loads on a check byte, drains on a result transfer
   always_comb begin
      if (req_xfer && !is_data) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;

   // Control state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_count_ff     <= DeviceCountReset;
         bytes_per_dev_ff <= BytesPerDeviceReset;
         crc_ff           <= CrcStart;
         byte_pos_ff      <= 6'd0;
         dev_pos_ff       <= 4'd0;
         mask_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_xfer) begin
            unique case (csr_index)
               RegDeviceCount:    dev_count_ff     <= csr_data[4:0];
               RegBytesPerDevice: bytes_per_dev_ff <= csr_data;
               default: ;
            endcase
         end
         crc_ff       <= crc_in;
         byte_pos_ff  <= byte_pos_in;
         dev_pos_ff   <= dev_pos_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (req_xfer && !is_data) begin
         rsp_data_ff <= {3'b000, mask_new, crc_base, rx_byte, pec_ok, dev_pos_base};
         rsp_last_ff <= last_dev;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Fields of the held result and frame-close conditions for the checks
   logic [3:0]           held_dev;
   logic                 held_ok;
   logic [7:0]           held_rx;
   logic [7:0]           held_crc;
   logic [MaskWidth-1:0] held_mask;
   logic                 check_last;
   logic                 frame_clear;

   assign held_dev    = rsp_data_ff[3:0];
   assign held_ok     = rsp_data_ff[4];
   assign held_rx     = rsp_data_ff[12:5];
   assign held_crc    = rsp_data_ff[20:13];
   assign held_mask   = rsp_data_ff[36:21];
   assign check_last  = req_xfer && !is_data && last_dev;
   assign frame_clear = (dev_pos_ff == 4'd0) && (mask_ff == '0) && (byte_pos_ff == 6'd0);

   // Checks
   `DCPC_ASSERT_SAME(a_ok_matches_pec, clock, reset, rsp_valid_ff, held_ok == (held_rx == held_crc))
   `DCPC_ASSERT_SAME(a_fail_sets_mask, clock, reset, rsp_valid_ff && !held_ok, held_mask[held_dev])
   `DCPC_ASSERT_NEXT(a_last_clears, clock, reset, check_last, frame_clear)

endmodule

FILE: verif/testbench.sv
// -----------------------------------------------------------------------------
// Daisy-chain PEC checker testbench
// Streams received bytes into the checker and predicts every check-byte
// result with a local CRC-8 and position tracker. Each result transfer is
// compared field by field against the oldest prediction. Directed tests
// cover reset values, empty segments, frame resync and reconfiguration
// mid-frame. Random frames then run under several register settings and
// idle patterns on both streams.
// -----------------------------------------------------------------------------
module testbench;
   import dcpc_pkg::*;

   // Register indexes that decode to no register
   localparam logic [CsrIndexWidth-1:0] RegSpareA = 2'd2;
   localparam logic [CsrIndexWidth-1:0] RegSpareB = 2'd3;

   localparam int StallLimit   = 2000;
   localparam int SettleCycles = 4;
   localparam int RandomItems  = 900;
   localparam int ReportLimit  = 10;

   typedef struct packed {
      logic [3:0]  device_index;
      logic        pec_ok;
      logic [7:0]  received_pec;
      logic [7:0]  computed_pec;
      logic [15:0] mismatch_mask;
      logic        last_device;
   } pec_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [ReqDataWidth-1:0]      req_tdata = '0;  // [7:0] rx_byte
   logic                         req_tuser = 1'b0; // [0] frame_start
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   // [3:0] device_index, [4] pec_ok, [12:5] received_pec,
   // [20:13] computed_pec, [36:21] mismatch_mask, [39:37] zero
   logic [RspDataWidth-1:0]      rsp_tdata;
   logic                         rsp_tlast;        // last_device
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CsrIndexWidth-1:0]     csr_index = '0;
   logic [CsrDataWidth-1:0]      csr_data = '0;

   // Predictor state and register copy
   logic [7:0]  crc_acc = CrcStart;
   logic [5:0]  seg_pos = '0;
   logic [3:0]  dev_pos = '0;
   logic [15:0] fail_bits = '0;
   logic [4:0]  cfg_devices = DeviceCountReset;
   logic [5:0]  cfg_bytes = BytesPerDeviceReset;

   pec_result_type expected_checks[$];
   int          fail_count = 0;
   int          sent_items = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;

   daisy_chain_pec_checker_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // CRC-8, MSB first, polynomial 0x07
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      int k;
      c = crc ^ b;
      for (k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction

   // Devices per frame after saturation
   function automatic logic [4:0] chain_length(input logic [4:0] n);
      if (n == 5'd0) return 5'd1;
      if (32'(n) > MaxDevices) return 5'(MaxDevices);
      if (n > 5'd16) return 5'd16;
      return n;
   endfunction

   // Advance the predictor by one accepted byte
   task automatic predict_byte(input logic [7:0] b, input logic s);
      pec_result_type r;
      if (s) begin
         crc_acc   = CrcStart;
         seg_pos   = '0;
         dev_pos   = '0;
         fail_bits = '0;
      end
      if (seg_pos < cfg_bytes) begin
         crc_acc = crc8_byte(crc_acc, b);
         seg_pos = seg_pos + 6'd1;
      end else begin
         r.device_index = dev_pos;
         r.pec_ok       = (b == crc_acc);
         r.received_pec = b;
         r.computed_pec = crc_acc;
         if (!r.pec_ok) fail_bits[dev_pos] = 1'b1;
         r.mismatch_mask = fail_bits;
         r.last_device   = (5'(dev_pos) + 5'd1) >= chain_length(cfg_devices);
         expected_checks.push_back(r);
         crc_acc = CrcStart;
         seg_pos = '0;
         if (r.last_device) begin
            dev_pos   = '0;
            fail_bits = '0;
         end else begin
            dev_pos = dev_pos + 4'd1;
         end
      end
   endtask

   // Compare one result transfer with the oldest prediction
   task automatic check_result();
      pec_result_type got, want;
      logic [2:0] pad;
      got = '{device_index: rsp_tdata[3:0], pec_ok: rsp_tdata[4],
              received_pec: rsp_tdata[12:5], computed_pec: rsp_tdata[20:13],
              mismatch_mask: rsp_tdata[36:21], last_device: rsp_tlast};
      pad = rsp_tdata[39:37];
      if (expected_checks.size() == 0) begin
         fail_count++;
         if (fail_count <= ReportLimit)
            $display("unexpected result: dev %0d ok %0b rx %02h crc %02h mask %04h last %0b",
                     got.device_index, got.pec_ok, got.received_pec, got.computed_pec,
                     got.mismatch_mask, got.last_device);
      end else begin
         want = expected_checks.pop_front();
         if (got.device_index != want.device_index || got.pec_ok != want.pec_ok ||
             got.received_pec != want.received_pec ||
             got.computed_pec != want.computed_pec ||
             got.mismatch_mask != want.mismatch_mask ||
             got.last_device != want.last_device || pad != 3'd0) begin
            fail_count++;
            if (fail_count <= ReportLimit) begin
               $display("mismatch exp: dev %0d ok %0b rx %02h crc %02h mask %04h last %0b",
                        want.device_index, want.pec_ok, want.received_pec,
                        want.computed_pec, want.mismatch_mask, want.last_device);
               $display("     act: dev %0d ok %0b rx %02h crc %02h mask %04h last %0b pad %0h",
                        got.device_index, got.pec_ok, got.received_pec,
                        got.computed_pec, got.mismatch_mask, got.last_device, pad);
            end
         end
      end
   endtask

   // Monitor: results first, then new bytes and register writes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) predict_byte(req_tdata, req_tuser);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               RegDeviceCount:    cfg_devices = csr_data[4:0];
               RegBytesPerDevice: cfg_bytes = csr_data;
               default: ;
            endcase
         end
      end
   end

   // Result backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Send one byte; called and returns at a rising edge
   task automatic send_byte(input logic [7:0] b, input logic s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= s;
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   // Stop sending and wait until every predicted result has arrived
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_checks.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] val);
      wait_until_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One frame of n_dev segments; mostly correct check bytes, rare resyncs
   task automatic send_frame(input int n_dev, input int seg_bytes, input bit mark_start);
      logic [7:0] crc, b;
      bit first;
      int d, i;
      first = mark_start;
      for (d = 0; d < n_dev; d++) begin
         crc = CrcStart;
         for (i = 0; i < seg_bytes; i++) begin
            b = 8'($urandom_range(0, 255));
            send_byte(b, first || ($urandom_range(0, 99) < 2));
            first = 1'b0;
            crc = crc8_byte(crc, b);
         end
         b = ($urandom_range(0, 99) < 85) ? crc : 8'($urandom_range(0, 255));
         send_byte(b, first);
         first = 1'b0;
      end
   endtask

   // Reset values: one device of 18 data bytes
   task automatic test_reset_defaults();
      logic [7:0] crc, b;
      int i;
      crc = CrcStart;
      for (i = 0; i < 18; i++) begin
         b = (i % 3 == 0) ? 8'h00 : ((i % 3 == 1) ? 8'hff : 8'h5a);
         send_byte(b, i == 0);
         crc = crc8_byte(crc, b);
      end
      send_byte(crc, 1'b0);
   endtask

   // No data bytes and device count zero: every byte closes a frame
   task automatic test_empty_segments();
      write_reg(RegDeviceCount, 6'd0);
      write_reg(RegBytesPerDevice, 6'd0);
      send_byte(CrcStart, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
   endtask

   // Frame start mid-frame drops the partial frame and its mask
   task automatic test_frame_resync();
      logic [7:0] crc;
      write_reg(RegDeviceCount, 6'd2);
      write_reg(RegBytesPerDevice, 6'd2);
      send_byte(8'h12, 1'b1);
      send_byte(8'h34, 1'b0);
      send_byte(8'h00, 1'b0);
      crc = crc8_byte(crc8_byte(CrcStart, 8'hab), 8'hcd);
      send_byte(8'hab, 1'b1);
      send_byte(8'hcd, 1'b0);
      send_byte(crc, 1'b0);
   endtask

   // Lowering the device count below the current position closes the frame
   task automatic test_midframe_reconfig();
      int d;
      write_reg(RegDeviceCount, 6'd4);
      write_reg(RegBytesPerDevice, 6'd1);
      for (d = 0; d < 3; d++) begin
         send_byte(8'(d + 1), d == 0);
         send_byte(8'hee, 1'b0);
      end
      write_reg(RegDeviceCount, 6'd2);
      send_byte(8'h77, 1'b0);
      send_byte(crc8_byte(CrcStart, 8'h77), 1'b0);
   endtask

   // Random frames over extreme and random settings and all idle patterns
   task automatic test_random_traffic();
      int ext_cnt [8] = '{16, 17, 31, 0, 1, 4, 16, 1};
      int ext_bpd [8] = '{1, 0, 2, 5, 63, 63, 0, 32};
      int phase, cnt, bpd, eff, frame_len, frames, f, n_dev, stop_at;
      stop_at = sent_items + RandomItems;
      phase = 0;
      while (sent_items < stop_at) begin
         if (phase < 8) begin
            cnt = ext_cnt[phase];
            bpd = ext_bpd[phase];
         end else begin
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
            bpd = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(0, 63);
         end
         eff = int'(chain_length(5'(cnt)));
         if (eff * (bpd + 1) > 260) bpd = $urandom_range(0, 7);
         frame_len = eff * (bpd + 1);
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 50; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 50; end
            default: begin send_idle_pct = 36; rsp_stall_pct = 36; end
         endcase
         write_reg(RegDeviceCount, 6'(cnt));
         write_reg(RegBytesPerDevice, 6'(bpd));
         if (phase % 5 == 2) write_reg((phase % 2) ? RegSpareA : RegSpareB,
                                       6'($urandom_range(0, 63)));
         frames = 200 / frame_len;
         if (frames < 1) frames = 1;
         if (frames > 5) frames = 5;
         for (f = 0; f < frames; f++) begin
            case ($urandom_range(0, 9))
               0: n_dev = (eff > 1) ? eff - 1 : 1;
               1: n_dev = eff + 1;
               default: n_dev = eff;
            endcase
            send_frame(n_dev, bpd, $urandom_range(0, 19) != 0);
         end
         phase++;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_empty_segments();
      test_frame_resync();
      test_midframe_reconfig();
      test_random_traffic();
      wait_until_idle();
      repeat (8) @(posedge clock);
      if (expected_checks.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
